FILE: rtl/core/jadb_pkg.sv
// Shared types and constants for the joystick axis dead zone and button block.
// Used by the axis lane, the event merge stage and the top level.
// No dependencies.
package jadb_pkg;

	localparam int unsigned PosW     = 16;
	localparam int unsigned GainW    = 32;
	localparam int unsigned ButtonW  = 32;
	localparam int unsigned MotionW  = 10;
	localparam int unsigned IdxW     = 5;
	localparam int unsigned OffW     = PosW + 1;
	localparam int unsigned ProdW    = OffW + GainW;
	localparam int unsigned FracW    = 16;
	localparam int unsigned InDataW  = 64;
	localparam int unsigned OutDataW = 32;
	localparam int unsigned ApbAddrW = 5;
	localparam int unsigned ApbDataW = 32;

	localparam logic signed [MotionW-1:0] MotionMax = 10'sd256;
	localparam logic signed [MotionW-1:0] MotionMin = -10'sd256;

	localparam logic [PosW-1:0]         CenterRst = 16'd32767;
	localparam logic [PosW-1:0]         DeadRst   = 16'd4915;
	localparam logic signed [GainW-1:0] XGainRst  = 32'sd602;
	localparam logic signed [GainW-1:0] YGainRst  = -32'sd602;

	typedef enum logic [2:0] {
		REG_X_CENTER    = 3'd0,
		REG_Y_CENTER    = 3'd1,
		REG_X_DEAD_ZONE = 3'd2,
		REG_Y_DEAD_ZONE = 3'd3,
		REG_X_GAIN      = 3'd4,
		REG_Y_GAIN      = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		KIND_AXIS   = 1'b0,
		KIND_BUTTON = 1'b1
	} kind_t;

	// load enables of the three lane stages
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} lane_ctl_t;

endpackage

FILE: rtl/core/jadb_axis_lane.sv
// One axis lane: center offset and dead zone, gain multiply, shift and clamp.
// Three register stages, loaded by the enables from the top level.
// Depends on jadb_pkg.
module jadb_axis_lane (
	input  logic                                  clk,
	input  jadb_pkg::lane_ctl_t                   ctl,
	input  logic [jadb_pkg::PosW-1:0]             position,
	input  logic [jadb_pkg::PosW-1:0]             center,
	input  logic [jadb_pkg::PosW-1:0]             dead_zone,
	input  logic signed [jadb_pkg::GainW-1:0]     gain,
	output logic signed [jadb_pkg::MotionW-1:0]   motion
);

	logic signed [jadb_pkg::OffW-1:0]    off;
	logic signed [jadb_pkg::OffW-1:0]    dead_s;
	logic [jadb_pkg::OffW-1:0]           mag;
	logic                                below;
	logic signed [jadb_pkg::OffW-1:0]    adj;
	logic signed [jadb_pkg::OffW-1:0]    adj_s1;
	logic signed [jadb_pkg::ProdW-1:0]   prod_s2;
	logic signed [jadb_pkg::ProdW-jadb_pkg::FracW-1:0] shifted;
	logic signed [jadb_pkg::MotionW-1:0] clamped;
	logic signed [jadb_pkg::MotionW-1:0] motion_s3;

	assign off    = $signed({1'b0, position}) - $signed({1'b0, center});
	assign dead_s = $signed({1'b0, dead_zone});
	assign mag    = off[jadb_pkg::OffW-1] ? jadb_pkg::OffW'(-off) : jadb_pkg::OffW'(off);
	assign below  = mag < {1'b0, dead_zone};
	// pull the offset toward zero by the dead zone
	assign adj    = off[jadb_pkg::OffW-1] ? off + dead_s : off - dead_s;

	// floor shift of the product, dropping the 16 fraction bits of the 16.16 gain
	assign shifted = prod_s2[jadb_pkg::ProdW-1:jadb_pkg::FracW];

	always_comb begin
		if (shifted > (jadb_pkg::ProdW-jadb_pkg::FracW)'(jadb_pkg::MotionMax)) begin
			clamped = jadb_pkg::MotionMax;
		end else if (shifted < (jadb_pkg::ProdW-jadb_pkg::FracW)'(jadb_pkg::MotionMin)) begin
			clamped = jadb_pkg::MotionMin;
		end else begin
			clamped = shifted[jadb_pkg::MotionW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			adj_s1 <= below ? '0 : adj;
		end
		if (ctl.en_s2) begin
			prod_s2 <= adj_s1 * gain;
		end
		if (ctl.en_s3) begin
			motion_s3 <= clamped;
		end
	end

	assign motion = motion_s3;

endmodule

FILE: rtl/core/jadb_event_merge.sv
// Merge stage: joins the two lane results with the button change mask of a poll
// and sends one axis word, then one word per changed button, through an output register.
// Depends on jadb_pkg.
module jadb_event_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_take,
	input  logic signed [jadb_pkg::MotionW-1:0]   in_x_motion,
	input  logic signed [jadb_pkg::MotionW-1:0]   in_y_motion,
	input  logic [jadb_pkg::ButtonW-1:0]          in_changed,
	input  logic [jadb_pkg::ButtonW-1:0]          in_buttons,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [jadb_pkg::OutDataW-1:0]         m_tdata,
	output logic                                  m_tuser,
	output logic                                  m_tlast
);

	logic                                job_valid_q;
	logic                                axis_sent_q;
	logic [jadb_pkg::ButtonW-1:0]        mask_q;
	logic [jadb_pkg::ButtonW-1:0]        btn_q;
	logic signed [jadb_pkg::MotionW-1:0] x_q;
	logic signed [jadb_pkg::MotionW-1:0] y_q;

	logic                                out_valid_q;
	jadb_pkg::kind_t                     out_kind_q;
	logic signed [jadb_pkg::MotionW-1:0] out_x_q;
	logic signed [jadb_pkg::MotionW-1:0] out_y_q;
	logic [jadb_pkg::IdxW-1:0]           out_idx_q;
	logic                                out_pressed_q;
	logic                                out_last_q;

	logic                                out_load;
	logic                                emit;
	logic [jadb_pkg::IdxW-1:0]           low_idx;
	logic [jadb_pkg::ButtonW-1:0]        mask_rest;
	logic                                word_last;

	assign out_load  = !out_valid_q || m_tready;
	assign emit      = job_valid_q && out_load;
	assign mask_rest = mask_q & (mask_q - jadb_pkg::ButtonW'(1));
	assign word_last = axis_sent_q ? (mask_rest == '0) : (mask_q == '0);
	assign in_take   = !job_valid_q || (emit && word_last);

	// lowest changed button first
	always_comb begin
		low_idx = '0;
		for (int i = jadb_pkg::ButtonW - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = jadb_pkg::IdxW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			axis_sent_q <= 1'b0;
		end else if (in_take) begin
			job_valid_q <= in_valid;
			axis_sent_q <= 1'b0;
		end else if (emit) begin
			axis_sent_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mask_q <= in_changed;
			btn_q  <= in_buttons;
			x_q    <= in_x_motion;
			y_q    <= in_y_motion;
		end else if (emit && axis_sent_q) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_last_q <= word_last;
			if (!axis_sent_q) begin
				out_kind_q    <= jadb_pkg::KIND_AXIS;
				out_x_q       <= x_q;
				out_y_q       <= y_q;
				out_idx_q     <= '0;
				out_pressed_q <= 1'b0;
			end else begin
				out_kind_q    <= jadb_pkg::KIND_BUTTON;
				out_x_q       <= '0;
				out_y_q       <= '0;
				out_idx_q     <= low_idx;
				out_pressed_q <= btn_q[low_idx];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = jadb_pkg::OutDataW'({out_pressed_q, out_idx_q, out_y_q, out_x_q});

`ifndef SYNTHESIS
	// once the axis word is out, a poll still in the slot has a button left to send
	a_pending_button: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_q && axis_sent_q) |-> (mask_q != '0))
		else $error("merge slot holds a poll with nothing left to send");

	a_button_no_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == jadb_pkg::KIND_BUTTON) |->
		(out_x_q == '0 && out_y_q == '0))
		else $error("button word carries motion");

	a_motion_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == jadb_pkg::KIND_AXIS) |->
		(out_x_q <= jadb_pkg::MotionMax && out_x_q >= jadb_pkg::MotionMin &&
		 out_y_q <= jadb_pkg::MotionMax && out_y_q >= jadb_pkg::MotionMin))
		else $error("axis motion outside clamp range");

	// a stalled word must not be overwritten by the next one
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(m_tdata) && $stable(m_tlast)))
		else $error("output word changed while stalled");
`endif

endmodule

FILE: rtl/core/joystick_axis_deadzone_and_buttons.sv
// Joystick poll conditioner: per-axis dead zone, gain and clamp, plus button change words.
// Slave stream s_*: one poll per word. s_tdata = x_position [15:0], y_position [31:16],
//   button_states [63:32].
// Master stream m_*: per poll one axis word, then one word per changed button, lowest
//   index first; m_tlast marks the final word of the poll, m_tuser is 0 for the axis
//   word and 1 for a button word.
// APB port: six registers at byte addresses 0x00..0x14 (x/y center, x/y dead zone,
//   x/y gain); write only while the block is idle.
// A poll's axis word passes lane stages s1 to s3, the merge slot and the output register.
// Throughput: a poll occupies the output for 1 + (changed buttons) words, 1 to 33; the
//   single output word register sets this, while the two axis lanes and the polls behind
//   them advance every cycle until the merge slot is full.
// When m_tready is low the output word holds, the merge slot and lane pipeline fill up
//   and s_tready falls after three more polls.
// Reset clears the register file to its defaults, the previous button state to zero and
//   all valid flags; a block fresh out of reset holds s_tready high, ready to take a poll.
// Depends on jadb_pkg, jadb_axis_lane and jadb_event_merge.
module joystick_axis_deadzone_and_buttons #(
	parameter int unsigned BUTTON_COUNT = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [jadb_pkg::ApbAddrW-1:0]     paddr,
	input  logic [jadb_pkg::ApbDataW-1:0]     pwdata,
	output logic [jadb_pkg::ApbDataW-1:0]     prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// x_position [15:0], y_position [31:16], button_states [63:32]
	input  logic [jadb_pkg::InDataW-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// x_motion [9:0], y_motion [19:10], button_index [24:20], pressed [25], zero [31:26]
	output logic [jadb_pkg::OutDataW-1:0]     m_tdata,
	// kind [0]
	output logic                              m_tuser,
	output logic                              m_tlast
);

	localparam logic [jadb_pkg::ButtonW-1:0] BtnMask =
		jadb_pkg::ButtonW'((64'd1 << BUTTON_COUNT) - 64'd1);

	logic [jadb_pkg::PosW-1:0]           x_center_q;
	logic [jadb_pkg::PosW-1:0]           y_center_q;
	logic [jadb_pkg::PosW-1:0]           x_dead_q;
	logic [jadb_pkg::PosW-1:0]           y_dead_q;
	logic signed [jadb_pkg::GainW-1:0]   x_gain_q;
	logic signed [jadb_pkg::GainW-1:0]   y_gain_q;
	logic [jadb_pkg::ButtonW-1:0]        prev_btn_q;

	logic                                cfg_wr;
	jadb_pkg::cfg_reg_t                  cfg_sel;

	logic                                valid_s1, valid_s2, valid_s3;
	logic [jadb_pkg::ButtonW-1:0]        changed_s1, changed_s2, changed_s3;
	logic [jadb_pkg::ButtonW-1:0]        btn_s1, btn_s2, btn_s3;
	logic                                ready_s2, ready_s3;
	logic                                merge_take;
	jadb_pkg::lane_ctl_t                 lane_ctl;
	logic signed [jadb_pkg::MotionW-1:0] x_motion, y_motion;
	logic [jadb_pkg::ButtonW-1:0]        in_buttons;
	logic                                in_acc;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = jadb_pkg::cfg_reg_t'(paddr[jadb_pkg::ApbAddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_center_q <= jadb_pkg::CenterRst;
			y_center_q <= jadb_pkg::CenterRst;
			x_dead_q   <= jadb_pkg::DeadRst;
			y_dead_q   <= jadb_pkg::DeadRst;
			x_gain_q   <= jadb_pkg::XGainRst;
			y_gain_q   <= jadb_pkg::YGainRst;
		end else if (cfg_wr) begin
			case (cfg_sel)
				jadb_pkg::REG_X_CENTER:    x_center_q <= pwdata[jadb_pkg::PosW-1:0];
				jadb_pkg::REG_Y_CENTER:    y_center_q <= pwdata[jadb_pkg::PosW-1:0];
				jadb_pkg::REG_X_DEAD_ZONE: x_dead_q   <= pwdata[jadb_pkg::PosW-1:0];
				jadb_pkg::REG_Y_DEAD_ZONE: y_dead_q   <= pwdata[jadb_pkg::PosW-1:0];
				jadb_pkg::REG_X_GAIN:      x_gain_q   <= $signed(pwdata);
				jadb_pkg::REG_Y_GAIN:      y_gain_q   <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			jadb_pkg::REG_X_CENTER:    prdata = jadb_pkg::ApbDataW'(x_center_q);
			jadb_pkg::REG_Y_CENTER:    prdata = jadb_pkg::ApbDataW'(y_center_q);
			jadb_pkg::REG_X_DEAD_ZONE: prdata = jadb_pkg::ApbDataW'(x_dead_q);
			jadb_pkg::REG_Y_DEAD_ZONE: prdata = jadb_pkg::ApbDataW'(y_dead_q);
			jadb_pkg::REG_X_GAIN:      prdata = x_gain_q;
			jadb_pkg::REG_Y_GAIN:      prdata = y_gain_q;
			default:                   prdata = '0;
		endcase
	end

	// lane pipeline flow control
	assign ready_s3 = !valid_s3 || merge_take;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign s_tready = !valid_s1 || ready_s2;
	assign in_acc   = s_tvalid && s_tready;

	assign lane_ctl.en_s1 = s_tready;
	assign lane_ctl.en_s2 = ready_s2;
	assign lane_ctl.en_s3 = ready_s3;

	assign in_buttons = s_tdata[jadb_pkg::InDataW-1:2*jadb_pkg::PosW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			prev_btn_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (in_acc) begin
				prev_btn_q <= in_buttons;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			changed_s1 <= (in_buttons ^ prev_btn_q) & BtnMask;
			btn_s1     <= in_buttons;
		end
		if (ready_s2) begin
			changed_s2 <= changed_s1;
			btn_s2     <= btn_s1;
		end
		if (ready_s3) begin
			changed_s3 <= changed_s2;
			btn_s3     <= btn_s2;
		end
	end

	jadb_axis_lane u_lane_x (
		.clk       (clk),
		.ctl       (lane_ctl),
		.position  (s_tdata[jadb_pkg::PosW-1:0]),
		.center    (x_center_q),
		.dead_zone (x_dead_q),
		.gain      (x_gain_q),
		.motion    (x_motion)
	);

	jadb_axis_lane u_lane_y (
		.clk       (clk),
		.ctl       (lane_ctl),
		.position  (s_tdata[2*jadb_pkg::PosW-1:jadb_pkg::PosW]),
		.center    (y_center_q),
		.dead_zone (y_dead_q),
		.gain      (y_gain_q),
		.motion    (y_motion)
	);

	jadb_event_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s3),
		.in_take     (merge_take),
		.in_x_motion (x_motion),
		.in_y_motion (y_motion),
		.in_changed  (changed_s3),
		.in_buttons  (btn_s3),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

FILE: tb/joystick_axis_deadzone_and_buttons_tb.sv
// Self-checking testbench for joystick_axis_deadzone_and_buttons: polls go in on the slave
// stream, conditioned axis and button-change words are checked on the master stream.
// Depends on jadb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module joystick_axis_deadzone_and_buttons_tb;

	localparam int unsigned ButtonCount = 32;
	localparam int unsigned RegCount    = 6;
	localparam int unsigned RegSpare0   = 6;
	localparam int unsigned RegSpare1   = 7;
	localparam int unsigned DrainCycles = 12;
	localparam int unsigned LongHold    = 300;
	localparam int unsigned StallLimit  = 3000;
	localparam int unsigned RandPolls   = 85;

	typedef struct packed {
		logic [jadb_pkg::ButtonW-1:0] buttons;
		logic [jadb_pkg::PosW-1:0]    y;
		logic [jadb_pkg::PosW-1:0]    x;
	} poll_t;

	typedef struct packed {
		jadb_pkg::kind_t                     kind;
		logic signed [jadb_pkg::MotionW-1:0] x_motion;
		logic signed [jadb_pkg::MotionW-1:0] y_motion;
		logic [jadb_pkg::IdxW-1:0]           button_index;
		logic                                pressed;
		logic                                last;
	} motion_word_t;

	typedef enum {TX_STEADY, TX_BURSTY} tx_mode_t;
	typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [jadb_pkg::ApbAddrW-1:0] paddr = '0;
	logic [jadb_pkg::ApbDataW-1:0] pwdata = '0;
	logic [jadb_pkg::ApbDataW-1:0] prdata;
	logic                          pready;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	// x_position [15:0], y_position [31:16], button_states [63:32]
	logic [jadb_pkg::InDataW-1:0]  s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// x_motion [9:0], y_motion [19:10], button_index [24:20], pressed [25], zero [31:26]
	logic [jadb_pkg::OutDataW-1:0] m_tdata;
	// kind [0]
	logic                          m_tuser;
	logic                          m_tlast;

	poll_t          pending_polls[$];
	motion_word_t   expected_words[$];
	logic [31:0]    shadow_regs[RegCount];
	logic [31:0]    held_buttons = '0;
	logic [31:0]    gen_buttons = '0;
	int unsigned    mismatches = 0;
	bit             poll_taken = 1'b0;
	tx_mode_t       tx_mode = TX_STEADY;
	rx_mode_t       rx_mode = RX_FREE;
	int unsigned    tx_burst_left = 0;
	int unsigned    tx_gap_left = 0;
	int unsigned    rx_phase = 0;
	int unsigned    hold_requests = 0;
	int unsigned    holds_started = 0;
	int unsigned    hold_left = 0;
	int unsigned    idle_cycles = 0;

	joystick_axis_deadzone_and_buttons #(
		.BUTTON_COUNT(ButtonCount)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		shadow_regs[jadb_pkg::REG_X_CENTER]    = 32'(jadb_pkg::CenterRst);
		shadow_regs[jadb_pkg::REG_Y_CENTER]    = 32'(jadb_pkg::CenterRst);
		shadow_regs[jadb_pkg::REG_X_DEAD_ZONE] = 32'(jadb_pkg::DeadRst);
		shadow_regs[jadb_pkg::REG_Y_DEAD_ZONE] = 32'(jadb_pkg::DeadRst);
		shadow_regs[jadb_pkg::REG_X_GAIN]      = jadb_pkg::XGainRst;
		shadow_regs[jadb_pkg::REG_Y_GAIN]      = jadb_pkg::YGainRst;
	end

	// dead zone, gain in 16.16 with floor rounding, clamp to the motion range
	function automatic logic signed [jadb_pkg::MotionW-1:0] condition_axis(
			logic [jadb_pkg::PosW-1:0] pos, logic [jadb_pkg::PosW-1:0] ctr,
			logic [jadb_pkg::PosW-1:0] dz, logic signed [jadb_pkg::GainW-1:0] gain);
		int     off;
		int     mag;
		longint prod;
		longint scaled;
		off = int'(pos) - int'(ctr);
		mag = (off < 0) ? -off : off;
		if (mag < int'(dz)) return '0;
		if (off > 0) off = off - int'(dz);
		else if (off < 0) off = off + int'(dz);
		prod = longint'(off) * longint'(gain);
		scaled = prod >>> jadb_pkg::FracW;
		if (scaled > 256) scaled = 256;
		else if (scaled < -256) scaled = -256;
		return scaled[jadb_pkg::MotionW-1:0];
	endfunction

	function automatic string word_text(motion_word_t w);
		return $sformatf("kind=%0d x=%0d y=%0d idx=%0d pressed=%b last=%b", w.kind,
			w.x_motion, w.y_motion, w.button_index, w.pressed, w.last);
	endfunction

	function automatic void predict_poll_words(poll_t p);
		motion_word_t w;
		logic [31:0]  changed;
		int           remaining;
		changed = p.buttons ^ held_buttons;
		remaining = $countones(changed);
		w.kind = jadb_pkg::KIND_AXIS;
		w.x_motion = condition_axis(p.x, shadow_regs[jadb_pkg::REG_X_CENTER][15:0],
			shadow_regs[jadb_pkg::REG_X_DEAD_ZONE][15:0],
			shadow_regs[jadb_pkg::REG_X_GAIN]);
		w.y_motion = condition_axis(p.y, shadow_regs[jadb_pkg::REG_Y_CENTER][15:0],
			shadow_regs[jadb_pkg::REG_Y_DEAD_ZONE][15:0],
			shadow_regs[jadb_pkg::REG_Y_GAIN]);
		w.button_index = '0;
		w.pressed = 1'b0;
		w.last = (remaining == 0);
		expected_words.push_back(w);
		for (int i = 0; i < ButtonCount; i++) begin
			if (changed[i]) begin
				remaining--;
				w.kind = jadb_pkg::KIND_BUTTON;
				w.x_motion = '0;
				w.y_motion = '0;
				w.button_index = jadb_pkg::IdxW'(i);
				w.pressed = p.buttons[i];
				w.last = (remaining == 0);
				expected_words.push_back(w);
			end
		end
		held_buttons = p.buttons;
	endfunction

	// input side: note each accepted poll and predict its words
	always @(posedge clk) begin
		poll_taken = arst_n && s_tvalid && s_tready;
		if (poll_taken) predict_poll_words(poll_t'(s_tdata));
	end

	// sender: back-to-back polls in steady mode, bursts of random length with random gaps in bursty mode
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || poll_taken) begin
			if (tx_gap_left != 0) begin
				tx_gap_left--;
				s_tvalid <= 1'b0;
				s_tdata <= {$urandom, $urandom};
			end else if (pending_polls.size() != 0) begin
				s_tdata <= pending_polls.pop_front();
				s_tvalid <= 1'b1;
				if (tx_mode == TX_BURSTY) begin
					if (tx_burst_left <= 1) begin
						tx_burst_left = $urandom_range(1, 12);
						tx_gap_left = $urandom_range(1, 9);
					end else begin
						tx_burst_left--;
					end
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern per mode, plus long hold-offs on request
	always @(negedge clk) begin
		rx_phase++;
		if (hold_requests != holds_started) begin
			holds_started = hold_requests;
			hold_left = LongHold;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: begin
					m_tready <= 1'b1;
				end
				RX_RANDOM: begin
					m_tready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					m_tready <= !((rx_phase % 11) < 3 || (rx_phase % 53) >= 45);
				end
			endcase
		end
	end

	// output side: compare each word with the oldest prediction
	always @(posedge clk) begin
		motion_word_t want;
		motion_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = jadb_pkg::kind_t'(m_tuser);
			got.x_motion = m_tdata[9:0];
			got.y_motion = m_tdata[19:10];
			got.button_index = m_tdata[24:20];
			got.pressed = m_tdata[25];
			got.last = m_tlast;
			if (expected_words.size() == 0) begin
				$display("%0t: word with nothing expected: %s pad=%h", $time,
					word_text(got), m_tdata[31:26]);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (got !== want || m_tdata[31:26] !== 6'd0) begin
					$display("%0t: word mismatch: expected %s, actual %s pad=%h", $time,
						word_text(want), word_text(got), m_tdata[31:26]);
					mismatches++;
				end
			end
		end
	end

	// end the run once nothing has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic logic [31:0] reg_mask(int unsigned idx);
		return (idx >= jadb_pkg::REG_X_GAIN) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
	endfunction

	task automatic write_reg(input int unsigned idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= jadb_pkg::ApbAddrW'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < RegCount) shadow_regs[idx] = val & reg_mask(idx);
	endtask

	task automatic check_regs();
		logic [31:0] rd;
		for (int unsigned idx = 0; idx < RegCount; idx++) begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= jadb_pkg::ApbAddrW'(idx * 4);
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			rd = prdata;
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			if ((rd & reg_mask(idx)) !== shadow_regs[idx]) begin
				$display("%0t: register %0d read mismatch: expected %h, actual %h",
					$time, idx, shadow_regs[idx], rd);
				mismatches++;
			end
		end
	endtask

	task automatic set_axes(input logic [15:0] xc, input logic [15:0] yc,
			input logic [15:0] xd, input logic [15:0] yd,
			input logic [31:0] xg, input logic [31:0] yg);
		write_reg(jadb_pkg::REG_X_CENTER, {16'(~xc), xc});
		write_reg(jadb_pkg::REG_Y_CENTER, {16'd0, yc});
		write_reg(jadb_pkg::REG_X_DEAD_ZONE, {16'd0, xd});
		write_reg(jadb_pkg::REG_Y_DEAD_ZONE, {16'hA5A5, yd});
		write_reg(jadb_pkg::REG_X_GAIN, xg);
		write_reg(jadb_pkg::REG_Y_GAIN, yg);
		check_regs();
	endtask

	// hold until every poll is taken and every word is back, then let the pipe settle
	task automatic wait_drained();
		while (pending_polls.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic queue_poll(input logic [15:0] x, input logic [15:0] y,
			input logic [31:0] b);
		poll_t p;
		p.x = x;
		p.y = y;
		p.buttons = b;
		pending_polls.push_back(p);
	endtask

	function automatic logic [15:0] rand_pos(logic [15:0] ctr, logic [15:0] dz);
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 65535);
			1: v = int'(ctr) + ($urandom_range(0, 1) ? int'(dz) : -int'(dz))
				+ int'($urandom_range(0, 4)) - 2;
			default: v = int'(ctr) + int'($urandom_range(0, int'(dz) + 3000))
				* ($urandom_range(0, 1) ? 1 : -1);
		endcase
		if (v < 0) v = 0;
		else if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	function automatic logic [31:0] rand_gain();
		int g;
		case ($urandom_range(0, 3))
			0: g = int'($urandom_range(0, 4000)) - 2000;
			1: g = int'($urandom_range(0, 400000)) - 200000;
			2: g = $urandom;
			default: g = int'($urandom_range(0, 1200)) - 600;
		endcase
		return g;
	endfunction

	function automatic logic [15:0] rand_center();
		return $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(20000, 45000));
	endfunction

	function automatic logic [15:0] rand_dead();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'($urandom);
			default: return 16'($urandom_range(1, 6000));
		endcase
	endfunction

	task automatic queue_random_polls(input int unsigned count);
		logic [31:0] flips;
		for (int unsigned n = 0; n < count; n++) begin
			case ($urandom_range(0, 7))
				0: flips = '0;
				1, 2, 3: flips = 32'd1 << $urandom_range(0, 31);
				4, 5: flips = $urandom & $urandom & $urandom;
				6: flips = $urandom;
				default: flips = ($urandom & $urandom) | (32'd1 << $urandom_range(0, 31));
			endcase
			gen_buttons = gen_buttons ^ flips;
			queue_poll(rand_pos(shadow_regs[jadb_pkg::REG_X_CENTER][15:0],
				shadow_regs[jadb_pkg::REG_X_DEAD_ZONE][15:0]),
				rand_pos(shadow_regs[jadb_pkg::REG_Y_CENTER][15:0],
				shadow_regs[jadb_pkg::REG_Y_DEAD_ZONE][15:0]), gen_buttons);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_regs();

		// defaults: center, extremes, offsets at and around the dead zone edge
		queue_poll(16'd32767, 16'd32767, 32'h0000_0000);
		queue_poll(16'd0, 16'd65535, 32'hFFFF_FFFF);
		queue_poll(16'd65535, 16'd0, 32'h0000_0000);
		queue_poll(16'd37682, 16'd27852, 32'h0000_0001);
		queue_poll(16'd37681, 16'd27853, 32'h8000_0001);
		queue_poll(16'd37683, 16'd27851, 32'h8000_0000);
		queue_poll(16'd27851, 16'd37683, 32'h0000_0000);
		wait_drained();

		// extreme registers; spare addresses must not disturb anything
		set_axes(16'd0, 16'd65535, 16'd0, 16'd65535, 32'h7FFF_FFFF, 32'h8000_0000);
		write_reg(RegSpare0, 32'hFFFF_FFFF);
		write_reg(RegSpare1, 32'h0000_0000);
		check_regs();
		queue_poll(16'd0, 16'd65535, 32'hAAAA_AAAA);
		queue_poll(16'd1, 16'd0, 32'h5555_5555);
		queue_poll(16'd65535, 16'd1, 32'h8000_0000);
		queue_poll(16'd32768, 16'd32767, 32'h0000_0000);
		wait_drained();

		// full-scale products on both signs must clamp, not wrap
		set_axes(16'd65535, 16'd0, 16'd0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_poll(16'd0, 16'd65535, 32'h0001_0000);
		queue_poll(16'd65534, 16'd1, 32'h0001_0000);
		queue_poll(16'd65535, 16'd0, 32'h0000_0000);
		wait_drained();

		// tiny gains: zero gain, and negative products rounding toward minus infinity
		set_axes(16'd32768, 16'd32768, 16'd0, 16'd0, 32'h0000_0000, 32'h0000_0001);
		queue_poll(16'd0, 16'd32767, 32'h0000_0000);
		queue_poll(16'd65535, 16'd0, 32'h0000_0000);
		queue_poll(16'd32768, 16'd65535, 32'h0000_0000);
		wait_drained();
		gen_buttons = held_buttons;

		for (int unsigned phase = 0; phase < 5; phase++) begin
			if (phase == 3)
				set_axes(16'd32767, 16'd32767, 16'd4915, 16'd4915, 32'd602, -32'sd602);
			else
				set_axes(rand_center(), rand_center(), rand_dead(), rand_dead(),
					rand_gain(), rand_gain());
			tx_mode = (phase == 1 || phase == 2) ? TX_STEADY : TX_BURSTY;
			case (phase)
				0: rx_mode = RX_RANDOM;
				1: rx_mode = RX_FREE;
				2: rx_mode = RX_PATTERN;
				3: rx_mode = RX_PATTERN;
				default: rx_mode = RX_RANDOM;
			endcase
			// back up the output while the sender keeps pushing polls
			if (phase == 2 || phase == 4) hold_requests++;
			queue_random_polls(RandPolls);
			wait_drained();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
